// File: hdl/swcpg_pkg.sv
package swcpg_pkg;

  // fixed field widths
  localparam int COORD_W = 9;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int LEVEL_W = 2 * DIFF_W;
  localparam int WORD_W  = 16;
  localparam int COLOR_W = 8;
  localparam int IN_W    = 24;
  localparam int OUT_W   = 24;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  localparam logic [WORD_W-1:0] GAIN_RESET  = 16'd668;
  localparam logic [WORD_W-1:0] PHASE_RESET = 16'd0;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X = 8'd0,
    REG_CENTER_Y = 8'd1,
    REG_GAIN     = 8'd2,
    REG_PHASE    = 8'd3
  } cfg_reg_t;

  // live configuration handed to the angle pipeline
  typedef struct packed {
    logic [COORD_W-1:0] center_x;
    logic [COORD_W-1:0] center_y;
    logic [WORD_W-1:0]  gain;
    logic [WORD_W-1:0]  phase;
  } cfg_t;

  // one colored pixel, red in the lowest bits
  typedef struct packed {
    logic [COLOR_W-1:0] blue;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] red;
  } pixel_t;

  localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // sine table entry from a 32-bit turn fraction t (evaluated at elaboration)
  function automatic logic [COLOR_W-1:0] rom_entry(input logic [63:0] t);
    logic [1:0]         quad;
    logic [63:0]        r;
    logic [63:0]        a;
    logic [63:0]        a2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        lifted;
    logic [63:0]        scaled;
    quad = t[31:30];
    r    = {34'd0, t[29:0]};
    a    = (r * HALF_PI_Q30) >> 30;
    a2   = (a * a) >> 30;
    if (quad[0] == 1'b0) begin
      // sine series up to the 15th order
      term = a;
      sum  = $signed(term);
      term = ((term * a2) >> 30) / 6;   sum = sum - $signed(term);
      term = ((term * a2) >> 30) / 20;  sum = sum + $signed(term);
      term = ((term * a2) >> 30) / 42;  sum = sum - $signed(term);
      term = ((term * a2) >> 30) / 72;  sum = sum + $signed(term);
      term = ((term * a2) >> 30) / 110; sum = sum - $signed(term);
      term = ((term * a2) >> 30) / 156; sum = sum + $signed(term);
      term = ((term * a2) >> 30) / 210; sum = sum - $signed(term);
    end else begin
      // cosine series up to the 14th order
      term = Q30_ONE;
      sum  = $signed(term);
      term = ((term * a2) >> 30) / 2;   sum = sum - $signed(term);
      term = ((term * a2) >> 30) / 12;  sum = sum + $signed(term);
      term = ((term * a2) >> 30) / 30;  sum = sum - $signed(term);
      term = ((term * a2) >> 30) / 56;  sum = sum + $signed(term);
      term = ((term * a2) >> 30) / 90;  sum = sum - $signed(term);
      term = ((term * a2) >> 30) / 132; sum = sum + $signed(term);
      term = ((term * a2) >> 30) / 182; sum = sum - $signed(term);
    end
    if (quad[1]) begin
      sum = -sum;
    end
    // clamp to [-1, 1] in Q30
    if (sum > $signed(Q30_ONE)) begin
      sum = $signed(Q30_ONE);
    end
    if (sum < -$signed(Q30_ONE)) begin
      sum = -$signed(Q30_ONE);
    end
    lifted = $unsigned(sum + $signed(Q30_ONE));
    scaled = (lifted * 64'd255) >> 31;
    return scaled[COLOR_W-1:0];
  endfunction

endpackage

// File: hdl/sine_wave_color_pattern_generator.sv
// channel   dir  signals                         contents
// s_axis    in   s_tvalid s_tready s_tdata[23:0]  pixel_x[8:0] pixel_y[17:9]
// m_axis    out  m_tvalid m_tready m_tdata[23:0]  red[7:0] green[15:8] blue[23:16]
// cfg       in   cfg_valid cfg_ready cfg_index cfg_data
//                                                 0 center_x, 1 center_y, 2 gain, 3 phase
//
// one pixel per clock while m_tready keeps the output draining; registered stages from input to m_tvalid
// (differences, level, scaled angle, table addresses, sine table read, output register)
// the table is constant, so there is no fill pass after reset; rst clears valid bits
// and sets the registers to their defaults
// stalls: a two-entry output buffer frees s_tready from m_tready; when its spare
// entry is full the whole pipeline holds in place
module sine_wave_color_pattern_generator #(
  parameter int IMAGE_SIZE   = 512,
  parameter int SINE_ENTRIES = 1024
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // transaction fields: pixel_x[8:0], pixel_y[17:9], zero fill
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [swcpg_pkg::IN_W-1:0]            s_tdata,
  // transaction fields: red[7:0], green[15:8], blue[23:16]
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  output logic [swcpg_pkg::OUT_W-1:0]           m_tdata,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [swcpg_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [swcpg_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int IDX_W = $clog2(SINE_ENTRIES);
  localparam logic [swcpg_pkg::COORD_W-1:0] CENTER_RESET =
    swcpg_pkg::COORD_W'(IMAGE_SIZE / 2);

  swcpg_pkg::cfg_t                   cfg;
  logic                              en;
  logic                              addr_valid;
  logic [IDX_W-1:0]                  idx_red;
  logic [IDX_W-1:0]                  idx_green;
  logic                              color_valid;
  logic [swcpg_pkg::COLOR_W-1:0]     red;
  logic [swcpg_pkg::COLOR_W-1:0]     green;
  swcpg_pkg::pixel_t                 pixel;
  swcpg_pkg::pixel_t                 out_pixel;

  assign cfg_ready = 1'b1;
  assign s_tready  = en;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.center_x <= CENTER_RESET;
      cfg.center_y <= CENTER_RESET;
      cfg.gain     <= swcpg_pkg::GAIN_RESET;
      cfg.phase    <= swcpg_pkg::PHASE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        swcpg_pkg::REG_CENTER_X: cfg.center_x <= cfg_data[swcpg_pkg::COORD_W-1:0];
        swcpg_pkg::REG_CENTER_Y: cfg.center_y <= cfg_data[swcpg_pkg::COORD_W-1:0];
        swcpg_pkg::REG_GAIN:     cfg.gain     <= cfg_data;
        swcpg_pkg::REG_PHASE:    cfg.phase    <= cfg_data;
        default: ;
      endcase
    end
  end

  // angle and table address pipeline
  swcpg_angle #(
    .SINE_ENTRIES(SINE_ENTRIES)
  ) u_angle (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .pixel_x   (s_tdata[8:0]),
    .pixel_y   (s_tdata[17:9]),
    .out_valid (addr_valid),
    .idx_red   (idx_red),
    .idx_green (idx_green)
  );

  // sine color lookup
  swcpg_sine_rom #(
    .SINE_ENTRIES(SINE_ENTRIES)
  ) u_sine_rom (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (addr_valid),
    .idx_red   (idx_red),
    .idx_green (idx_green),
    .out_valid (color_valid),
    .red       (red),
    .green     (green)
  );

  // blue is the bitwise inverse of green
  always_comb begin
    pixel.red   = red;
    pixel.green = green;
    pixel.blue  = ~green;
  end

  // output buffer
  swcpg_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (color_valid && en),
    .push_data (pixel),
    .ready     (en),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_pixel)
  );

  assign m_tdata = out_pixel;

endmodule

// File: hdl/swcpg_angle.sv
module swcpg_angle #(
  parameter int SINE_ENTRIES = 1024,
  localparam int IDX_W = $clog2(SINE_ENTRIES)
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  swcpg_pkg::cfg_t                     cfg,
  input  logic                                in_valid,
  input  logic [swcpg_pkg::COORD_W-1:0]       pixel_x,
  input  logic [swcpg_pkg::COORD_W-1:0]       pixel_y,
  output logic                                out_valid,
  output logic [IDX_W-1:0]                    idx_red,
  output logic [IDX_W-1:0]                    idx_green
);

  localparam int PW       = swcpg_pkg::WORD_W + $clog2(SINE_ENTRIES + 1);
  localparam int SCALED_W = swcpg_pkg::LEVEL_W + 17;

  logic                                     v1;
  logic                                     v2;
  logic                                     v3;
  logic signed [swcpg_pkg::DIFF_W-1:0]      dx;
  logic signed [swcpg_pkg::DIFF_W-1:0]      dy;
  logic signed [swcpg_pkg::LEVEL_W-1:0]     level;
  logic [swcpg_pkg::WORD_W-1:0]             turn_part;
  logic signed [SCALED_W-1:0]               scaled;
  logic [swcpg_pkg::WORD_W-1:0]             angle;
  logic [swcpg_pkg::WORD_W-1:0]             angle2;
  logic [PW-1:0]                            prod_red;
  logic [PW-1:0]                            prod_green;

  // level times gain, bits 23:8 form the angle
  assign scaled = SCALED_W'(level) * SCALED_W'($signed({1'b0, cfg.gain}));

  // angle plus phase, doubled angle, and table addresses
  always_comb begin
    angle      = turn_part + cfg.phase;
    angle2     = {angle[swcpg_pkg::WORD_W-2:0], 1'b0};
    prod_red   = PW'(angle) * PW'(SINE_ENTRIES);
    prod_green = PW'(angle2) * PW'(SINE_ENTRIES);
  end

  // valid bits follow the data through the stages
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      out_valid <= v3;
    end
  end

  // datapath stages: differences, level, scaled angle, addresses
  always_ff @(posedge clk) begin
    if (en) begin
      dx        <= $signed({1'b0, pixel_x}) - $signed({1'b0, cfg.center_x});
      dy        <= $signed({1'b0, pixel_y}) - $signed({1'b0, cfg.center_y});
      level     <= swcpg_pkg::LEVEL_W'(dx) * swcpg_pkg::LEVEL_W'(dy);
      turn_part <= scaled[23:8];
      idx_red   <= prod_red[swcpg_pkg::WORD_W +: IDX_W];
      idx_green <= prod_green[swcpg_pkg::WORD_W +: IDX_W];
    end
  end

endmodule

// File: hdl/swcpg_sine_rom.sv
module swcpg_sine_rom #(
  parameter int SINE_ENTRIES = 1024,
  localparam int IDX_W = $clog2(SINE_ENTRIES)
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  logic                             in_valid,
  input  logic [IDX_W-1:0]                 idx_red,
  input  logic [IDX_W-1:0]                 idx_green,
  output logic                             out_valid,
  output logic [swcpg_pkg::COLOR_W-1:0]    red,
  output logic [swcpg_pkg::COLOR_W-1:0]    green
);

  logic [swcpg_pkg::COLOR_W-1:0] sine_lut [SINE_ENTRIES];

  // table contents fixed at elaboration
  for (genvar k = 0; k < SINE_ENTRIES; k++) begin : g_lut
    localparam logic [63:0] TURN = (64'(k) << 32) / 64'(SINE_ENTRIES);
    assign sine_lut[k] = swcpg_pkg::rom_entry(TURN);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  // two registered read ports
  always_ff @(posedge clk) begin
    if (en) begin
      red   <= sine_lut[idx_red];
      green <= sine_lut[idx_green];
    end
  end

endmodule

// File: hdl/swcpg_skid.sv
module swcpg_skid (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  swcpg_pkg::pixel_t   push_data,
  output logic                ready,
  output logic                out_valid,
  input  logic                out_ready,
  output swcpg_pkg::pixel_t   out_data
);

  logic              spare_valid;
  swcpg_pkg::pixel_t spare;

  assign ready = !spare_valid;

  // output register with one spare entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      spare_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (spare_valid) begin
        out_valid   <= 1'b1;
        spare_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      spare_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      out_data <= spare_valid ? spare : push_data;
    end else if (push) begin
      spare <= push_data;
    end
  end

  // spare entry only fills behind a held output
  a_spare_behind_out: assert property (@(posedge clk) disable iff (rst)
    spare_valid |-> out_valid)
    else $error("skid spare holds data with empty output");

  // upstream never pushes while the spare is full
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    !(push && spare_valid))
    else $error("push into full skid buffer");

  // a drained output is refilled from the spare
  a_spare_moves: assert property (@(posedge clk) disable iff (rst)
    spare_valid && out_ready |=> out_valid && !spare_valid)
    else $error("spare entry not moved to output");

  // a held output with full spare keeps the spare
  a_spare_holds: assert property (@(posedge clk) disable iff (rst)
    spare_valid && !out_ready |=> spare_valid)
    else $error("spare entry lost while stalled");

endmodule
